>>> rtl/diuv_pkg.sv
// Shared constants and types of the depth inversion and uv scatter block.
`timescale 1ns / 1ps

package diuv_pkg;

   // Field widths of the request and response words.
   localparam int RAW_W       = 16;
   localparam int COORD_W     = 17;
   localparam int COORD_FRAC  = 16;
   localparam int ADDR_PORT_W = 19;
   localparam int MAX_W       = 16;
   localparam int FACT_W      = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   // Depth of the queue between front and back.
   localparam int FIFO_DEPTH  = 4;

   // Request kinds.
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_START = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PIXEL   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CORR_FACTOR = 1'b1;

   localparam logic [MAX_W-1:0]  MAX_PIXEL_RESET   = 16'hFFFF;
   localparam logic [FACT_W-1:0] CORR_FACTOR_RESET = 8'd1;

   // Classification of one queued word.
   typedef struct packed {
      logic [1:0] kind;   // request kind
      logic       hit;    // write lands in the store, or read address is inside
      logic       oor;    // write position fell outside the frame
   } flags_type;

endpackage

>>> rtl/diuv_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module diuv_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/diuv_fifo.sv
// Short word queue between the front and back parts.
`timescale 1ns / 1ps

module diuv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty,
   output logic [CNT_W-1:0] count
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata = store_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

>>> rtl/diuv_front.sv
// Front part: registers a request, maps uv to a frame index and classifies it.
`timescale 1ns / 1ps

module diuv_front import diuv_pkg::*; #(
   parameter int OUT_WIDTH  = 640,
   parameter int OUT_HEIGHT = 480,
   localparam int FRAME_SIZE = OUT_WIDTH * OUT_HEIGHT,
   localparam int ADDR_W     = $clog2(FRAME_SIZE)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [1:0]             req_type,
   input  logic [RAW_W-1:0]       depth_raw,
   input  logic [COORD_W-1:0]     u_coord,
   input  logic [COORD_W-1:0]     v_coord,
   input  logic [ADDR_PORT_W-1:0] read_address,
   output logic                   push,
   output flags_type              push_flags,
   output logic [RAW_W-1:0]       push_raw,
   output logic [ADDR_W-1:0]      push_index
);

   localparam int UPW = COORD_W + $clog2(OUT_WIDTH + 1);
   localparam int VPW = COORD_W + $clog2(OUT_HEIGHT + 1);
   localparam int CW  = UPW - COORD_FRAC;
   localparam int RW  = VPW - COORD_FRAC;

   logic [UPW-1:0]    u_prod;
   logic [VPW-1:0]    v_prod;
   logic [31:0]       addr_wide;

   logic              valid_ff, valid_in;
   logic [1:0]        kind_ff, kind_in;
   logic [RAW_W-1:0]  raw_ff, raw_in;
   logic              nz_ff, nz_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic              rhit_ff, rhit_in;
   logic [ADDR_W-1:0] raddr_ff, raddr_in;

   logic              in_frame;

   // Stage one: scale the coordinates and check the read address.
   always_comb begin
      u_prod    = UPW'(u_coord) * UPW'(OUT_WIDTH);
      v_prod    = VPW'(v_coord) * VPW'(OUT_HEIGHT);
      addr_wide = 32'(read_address);
      valid_in  = accept;
      kind_in   = accept ? req_type : kind_ff;
      raw_in    = accept ? depth_raw : raw_ff;
      nz_in     = accept ? ((u_coord != '0) && (v_coord != '0)) : nz_ff;
      col_in    = accept ? u_prod[UPW-1:COORD_FRAC] : col_ff;
      row_in    = accept ? v_prod[VPW-1:COORD_FRAC] : row_ff;
      rhit_in   = accept ? (addr_wide < 32'(FRAME_SIZE)) : rhit_ff;
      raddr_in  = accept ? addr_wide[ADDR_W-1:0] : raddr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      kind_ff  <= kind_in;
      raw_ff   <= raw_in;
      nz_ff    <= nz_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      rhit_ff  <= rhit_in;
      raddr_ff <= raddr_in;
   end

   // Stage two: classify and form the store index, then push.
   always_comb begin
      in_frame        = (col_ff < CW'(OUT_WIDTH)) && (row_ff < RW'(OUT_HEIGHT));
      push            = valid_ff;
      push_raw        = raw_ff;
      push_flags.kind = kind_ff;
      push_flags.oor  = (kind_ff == REQ_WRITE) && nz_ff && !in_frame;
      case (kind_ff)
         REQ_WRITE: begin
            push_flags.hit = nz_ff && in_frame;
            push_index     = ADDR_W'(row_ff) * ADDR_W'(OUT_WIDTH) + ADDR_W'(col_ff);
         end
         REQ_READ: begin
            push_flags.hit = rhit_ff;
            push_index     = raddr_ff;
         end
         default: begin
            push_flags.hit = 1'b0;
            push_index     = raddr_ff;
         end
      endcase
   end

endmodule

>>> rtl/diuv_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module diuv_div import diuv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAW_W-1:0]  dividend,
   input  logic [FACT_W-1:0] divisor,
   output logic              done,
   output logic [RAW_W-1:0]  quot,
   output logic [FACT_W-1:0] rem
);

   localparam int STEP_W = $clog2(RAW_W);

   typedef enum logic {D_IDLE, D_RUN} div_state_type;

   div_state_type      state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [RAW_W-1:0]   quot_ff, quot_in;
   logic [FACT_W-1:0]  rem_ff, rem_in;
   logic [FACT_W-1:0]  dsr_ff, dsr_in;
   logic               done_ff, done_in;

   logic [FACT_W:0]    trial;
   logic [FACT_W:0]    diff;
   logic               ge;

   always_comb begin
      trial    = {rem_ff, quot_ff[RAW_W-1]};
      diff     = trial - {1'b0, dsr_ff};
      ge       = (trial >= {1'b0, dsr_ff});
      state_in = state_ff;
      step_in  = step_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      done_in  = 1'b0;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               quot_in  = dividend;
               rem_in   = '0;
               dsr_in   = divisor;
               step_in  = '0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            // Shift in one bit, subtract where the trial remainder allows.
            quot_in = {quot_ff[RAW_W-2:0], ge};
            rem_in  = ge ? diff[FACT_W-1:0] : trial[FACT_W-1:0];
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(RAW_W - 1)) begin
               done_in  = 1'b1;
               state_in = D_IDLE;
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

>>> rtl/diuv_back.sv
// Back part: registers, divider, frame store, clearing sweep and responses.
`timescale 1ns / 1ps

module diuv_back import diuv_pkg::*; #(
   parameter int OUT_WIDTH  = 640,
   parameter int OUT_HEIGHT = 480,
   localparam int FRAME_SIZE = OUT_WIDTH * OUT_HEIGHT,
   localparam int ADDR_W     = $clog2(FRAME_SIZE)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   head_empty,
   input  flags_type              head_flags,
   input  logic [RAW_W-1:0]       head_raw,
   input  logic [ADDR_W-1:0]      head_index,
   output logic                   pop,
   output logic                   clearing,
   output logic                   rsp_valid,
   output logic [RAW_W-1:0]       rsp_pixel_value,
   output logic                   rsp_placed,
   output logic [ADDR_PORT_W-1:0] rsp_placed_index,
   output logic                   rsp_out_of_range
);

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_READ, S_CLEAR} back_state_type;

   back_state_type         state_ff, state_in;
   flags_type              flags_ff, flags_in;
   logic [ADDR_W-1:0]      index_ff, index_in;
   logic [ADDR_W-1:0]      sweep_ff, sweep_in;
   logic [MAX_W-1:0]       max_ff, max_in;
   logic [FACT_W-1:0]      fact_ff, fact_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RAW_W-1:0]       rsp_pixel_ff, rsp_pixel_in;
   logic                   rsp_placed_ff, rsp_placed_in;
   logic [ADDR_PORT_W-1:0] rsp_index_ff, rsp_index_in;
   logic                   rsp_oor_ff, rsp_oor_in;

   logic                   ram_en, ram_we;
   logic [ADDR_W-1:0]      ram_addr;
   logic [RAW_W-1:0]       ram_wdata, ram_rdata;

   logic                   div_start, div_done;
   logic [RAW_W-1:0]       div_quot;
   logic [FACT_W-1:0]      div_rem;

   logic [RAW_W:0]         ceil_q;
   logic [RAW_W-1:0]       corrected;
   logic [31:0]            index_wide;

   diuv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (head_raw),
      .divisor  (fact_ff),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   diuv_ram #(
      .DATA_W (RAW_W),
      .DEPTH  (FRAME_SIZE)
   ) u_frame (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      // Round the quotient up, then invert against full scale.
      ceil_q     = {1'b0, div_quot} + (RAW_W+1)'(div_rem != '0);
      corrected  = ((fact_ff == '0) || (ceil_q >= {1'b0, max_ff})) ? '0
                   : max_ff - ceil_q[RAW_W-1:0];
      index_wide = 32'(index_ff);

      state_in      = state_ff;
      flags_in      = flags_ff;
      index_in      = index_ff;
      sweep_in      = sweep_ff;
      max_in        = max_ff;
      fact_in       = fact_ff;
      rsp_valid_in  = 1'b0;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_placed_in = rsp_placed_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_oor_in    = rsp_oor_ff;
      pop           = 1'b0;
      div_start     = 1'b0;
      ram_en        = 1'b0;
      ram_we        = 1'b0;
      ram_addr      = index_ff;
      ram_wdata     = corrected;

      if (csr_we) begin
         case (csr_index)
            CSR_MAX_PIXEL:   max_in  = csr_wdata[MAX_W-1:0];
            CSR_CORR_FACTOR: fact_in = csr_wdata[FACT_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (!head_empty) begin
               pop      = 1'b1;
               flags_in = head_flags;
               index_in = head_index;
               case (head_flags.kind)
                  REQ_WRITE: begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
                  REQ_READ: begin
                     if (head_flags.hit) begin
                        ram_en   = 1'b1;
                        ram_addr = head_index;
                        state_in = S_READ;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_pixel_in  = '0;
                        rsp_placed_in = 1'b0;
                        rsp_index_in  = '0;
                        rsp_oor_in    = 1'b0;
                     end
                  end
                  REQ_START: begin
                     // Answer at once, then sweep the store.
                     rsp_valid_in  = 1'b1;
                     rsp_pixel_in  = '0;
                     rsp_placed_in = 1'b0;
                     rsp_index_in  = '0;
                     rsp_oor_in    = 1'b0;
                     sweep_in      = '0;
                     state_in      = S_CLEAR;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_pixel_in  = '0;
                     rsp_placed_in = 1'b0;
                     rsp_index_in  = '0;
                     rsp_oor_in    = 1'b0;
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               ram_en        = flags_ff.hit;
               ram_we        = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_pixel_in  = corrected;
               rsp_placed_in = flags_ff.hit;
               rsp_index_in  = flags_ff.hit ? index_wide[ADDR_PORT_W-1:0] : '0;
               rsp_oor_in    = flags_ff.oor;
               state_in      = S_IDLE;
            end
         end
         S_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_pixel_in  = ram_rdata;
            rsp_placed_in = 1'b0;
            rsp_index_in  = '0;
            rsp_oor_in    = 1'b0;
            state_in      = S_IDLE;
         end
         S_CLEAR: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = sweep_ff;
            ram_wdata = '0;
            sweep_in  = sweep_ff + ADDR_W'(1);
            if (sweep_ff == ADDR_W'(FRAME_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         max_ff       <= MAX_PIXEL_RESET;
         fact_ff      <= CORR_FACTOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         max_ff       <= max_in;
         fact_ff      <= fact_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      flags_ff      <= flags_in;
      index_ff      <= index_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_placed_ff <= rsp_placed_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_oor_ff    <= rsp_oor_in;
   end

   assign clearing         = (state_ff == S_CLEAR);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_value  = rsp_pixel_ff;
   assign rsp_placed       = rsp_placed_ff;
   assign rsp_placed_index = rsp_index_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

>>> rtl/depth_invert_and_uv_scatter.sv
// Top level of the depth inversion and uv scatter block.
`timescale 1ns / 1ps

// Usage:
//   Request channel: drive req_* and raise start; a word is taken at a rising
//   edge where start is high and busy is low. req_type selects write (invert
//   the depth sample and scatter it by uv), read (return one stored pixel) or
//   start (answer, then clear the frame store).
//   Response channel: every request gives one word, shown on rsp_* for one
//   cycle with rsp_valid high. The receiver cannot stall; take it then.
//   Registers: csr_we, csr_index and csr_wdata write max_pixel_value (index 0)
//   or correction_factor (index 1); write only while idle.
// Flow:
//   A write passes the front register, the queue, the pop that starts the
//   bit-serial divider of raw / factor, its done flag and the response
//   register, where ceil(raw / factor) is inverted. A read passes the front
//   register, the queue, the pop with the frame RAM's registered read and
//   the response register. The back part serves one word at a time and takes
//   no new word before the last one is through; a 4-word queue lets the front
//   keep accepting meanwhile. After reset and after every start the store is
//   swept to zero, one pixel a cycle, over all OUT_WIDTH * OUT_HEIGHT pixels
//   (307200 at 640x480); busy stays high for that sweep.
module depth_invert_and_uv_scatter import diuv_pkg::*; #(
   parameter int OUT_WIDTH  = 640,
   parameter int OUT_HEIGHT = 480
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_type,
   input  logic [RAW_W-1:0]       req_depth_raw,
   input  logic [COORD_W-1:0]     req_u_coord,
   input  logic [COORD_W-1:0]     req_v_coord,
   input  logic [ADDR_PORT_W-1:0] req_read_address,
   output logic                   rsp_valid,
   output logic [RAW_W-1:0]       rsp_pixel_value,
   output logic                   rsp_placed,
   output logic [ADDR_PORT_W-1:0] rsp_placed_index,
   output logic                   rsp_out_of_range,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FRAME_SIZE = OUT_WIDTH * OUT_HEIGHT;
   localparam int ADDR_W     = $clog2(FRAME_SIZE);
   localparam int FLAGS_W    = $bits(flags_type);
   localparam int ENTRY_W    = FLAGS_W + RAW_W + ADDR_W;
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   logic               accept;
   logic               push;
   flags_type          push_flags;
   logic [RAW_W-1:0]   push_raw;
   logic [ADDR_W-1:0]  push_index;

   logic [ENTRY_W-1:0] fifo_wdata, fifo_rdata;
   logic               fifo_empty;
   logic [CNT_W-1:0]   fifo_count;
   logic               pop;

   flags_type          head_flags;
   logic [RAW_W-1:0]   head_raw;
   logic [ADDR_W-1:0]  head_index;
   logic               clearing;

   // Hold off requests during a sweep, and whenever the words already in
   // flight could fill the queue.
   assign busy   = clearing || ((int'(fifo_count) + int'(push)) >= FIFO_DEPTH);
   assign accept = start && !busy;

   diuv_front #(
      .OUT_WIDTH  (OUT_WIDTH),
      .OUT_HEIGHT (OUT_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_type     (req_type),
      .depth_raw    (req_depth_raw),
      .u_coord      (req_u_coord),
      .v_coord      (req_v_coord),
      .read_address (req_read_address),
      .push         (push),
      .push_flags   (push_flags),
      .push_raw     (push_raw),
      .push_index   (push_index)
   );

   // Pack the classified word for the queue and unpack the head.
   assign fifo_wdata = {push_flags, push_raw, push_index};
   assign head_flags = flags_type'(fifo_rdata[ENTRY_W-1 -: FLAGS_W]);
   assign head_raw   = fifo_rdata[ADDR_W +: RAW_W];
   assign head_index = fifo_rdata[ADDR_W-1:0];

   diuv_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (FIFO_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (fifo_wdata),
      .pop   (pop),
      .rdata (fifo_rdata),
      .empty (fifo_empty),
      .count (fifo_count)
   );

   // Back part: owns the registers, the divider and the frame store, and
   // drives the response strobe.
   diuv_back #(
      .OUT_WIDTH  (OUT_WIDTH),
      .OUT_HEIGHT (OUT_HEIGHT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .head_empty       (fifo_empty),
      .head_flags       (head_flags),
      .head_raw         (head_raw),
      .head_index       (head_index),
      .pop              (pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_placed       (rsp_placed),
      .rsp_placed_index (rsp_placed_index),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule
